// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the heap queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define BMHQ_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define BMHQ_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bmhq_pkg.sv =====
// Request and response types and codes of the binary min-heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int VALUE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 11;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  popped_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

endpackage

// ===== rtl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue built around a one-write, two-read memory.
//
//   Channel   Direction   Ports                          Contents
//   in        input       in_valid, in_ready, in_req     push value or pop minimum
//   out       output      out_valid, out_ready, out_rsp  popped value, status, count
//
// A push moves larger parents down one level at a time in S_UP, then writes its value; a pop
// reads the root and the last entry, then sinks the last entry through S_DOWN and S_LAST.
// Each tree level costs one memory read (two on the way down) and one compare, issued back to back.
// Rejected pushes and pops finish in the cycle they are accepted.
// A new request is taken as soon as the core is free; a result that cannot leave waits
// in the output register, and the next finish holds until it drains.
// Reset empties the queue at once; memory contents are only used once written.
`timescale 1ns / 1ps

module binary_min_heap_queue #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmhq_pkg::in_item_t  in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output bmhq_pkg::out_item_t out_rsp
);

  localparam int SB = (VALUE_BITS < bmhq_pkg::VALUE_W) ? VALUE_BITS : bmhq_pkg::VALUE_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_DOWN   = 3'd3;
  localparam logic [2:0] S_LAST   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_RES    = 3'd6;

  function automatic logic [AW-1:0] pidx(input logic [CW:0] p);
    logic [CW:0] d;
    d = p - (CW+1)'(1);
    return d[AW-1:0];
  endfunction

  logic [SB-1:0] mem [CAPACITY];
  logic [SB-1:0] qa, qb;
  logic          mem_we;
  logic [AW-1:0] mem_wa, ra_a, ra_b;
  logic [SB-1:0] mem_wd;

  logic [2:0]                     state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  cur_r, cur_nxt;
  logic [SB-1:0]                  v_r, v_nxt;
  logic [bmhq_pkg::VALUE_W-1:0]   res_val_r, res_val_nxt;
  logic [bmhq_pkg::STATUS_W-1:0]  res_st_r, res_st_nxt;
  logic                           out_valid_r;
  bmhq_pkg::out_item_t            out_rsp_r;

  logic          out_free, finish, load_out;
  logic [CW:0]   cur_ext, n_ext, lc, sel, nlc, nrc;
  logic [CW-1:0] cnt_inc, par;
  logic          a_lt_b;
  logic [SB-1:0] smin;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign cur_ext = {1'b0, cur_r};
  assign n_ext   = {1'b0, count_r};
  assign cnt_inc = count_r + CW'(1);
  assign par     = cur_r >> 1;
  assign lc      = {cur_r, 1'b0};
  assign a_lt_b  = (qa < qb);
  assign sel     = a_lt_b ? lc : (lc | (CW+1)'(1));
  assign smin    = a_lt_b ? qa : qb;
  assign nlc     = {sel[CW-1:0], 1'b0};
  assign nrc     = {sel[CW-1:0], 1'b1};

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    v_nxt       = v_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    mem_we      = 1'b0;
    mem_wa      = pidx(cur_ext);
    mem_wd      = v_r;
    ra_a        = '0;
    ra_b        = '0;
    finish      = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_val_nxt = '0;
          res_st_nxt  = bmhq_pkg::ST_DONE;
          if (in_req.cmd == bmhq_pkg::CMD_PUSH) begin
            if (count_r == CW'(CAPACITY)) begin
              res_st_nxt = bmhq_pkg::ST_FULL;
              finish     = 1'b1;
            end else begin
              count_nxt = cnt_inc;
              cur_nxt   = cnt_inc;
              v_nxt     = in_req.value[SB-1:0];
              ra_a      = pidx({1'b0, cnt_inc >> 1});
              state_nxt = (count_r == '0) ? S_FIN : S_UP;
            end
          end else begin
            if (count_r == '0) begin
              res_st_nxt = bmhq_pkg::ST_EMPTY;
              finish     = 1'b1;
            end else begin
              count_nxt = count_r - CW'(1);
              ra_a      = pidx((CW+1)'(1));
              ra_b      = pidx(n_ext);
              state_nxt = S_PSTART;
            end
          end
        end
      end
      S_UP: begin
        mem_we = 1'b1;
        if (qa > v_r) begin
          mem_wd  = qa;
          cur_nxt = par;
          if (par == CW'(1)) begin
            state_nxt = S_FIN;
          end else begin
            ra_a = pidx({1'b0, par >> 1});
          end
        end else begin
          finish = 1'b1;
        end
      end
      S_PSTART: begin
        res_val_nxt = bmhq_pkg::VALUE_W'(qa);
        v_nxt       = qb;
        cur_nxt     = CW'(1);
        if (n_ext >= (CW+1)'(3)) begin
          ra_a      = pidx((CW+1)'(2));
          ra_b      = pidx((CW+1)'(3));
          state_nxt = S_DOWN;
        end else if (n_ext == (CW+1)'(2)) begin
          ra_a      = pidx((CW+1)'(2));
          state_nxt = S_LAST;
        end else begin
          mem_we = 1'b1;
          mem_wa = pidx((CW+1)'(1));
          mem_wd = qb;
          finish = 1'b1;
        end
      end
      S_DOWN: begin
        mem_we = 1'b1;
        if (smin < v_r) begin
          mem_wd  = smin;
          cur_nxt = sel[CW-1:0];
          if (nrc <= n_ext) begin
            ra_a = pidx(nlc);
            ra_b = pidx(nrc);
          end else if (nlc == n_ext) begin
            ra_a      = pidx(nlc);
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          finish = 1'b1;
        end
      end
      S_LAST: begin
        mem_we = 1'b1;
        if (qa < v_r) begin
          mem_wd    = qa;
          cur_nxt   = lc[CW-1:0];
          state_nxt = S_FIN;
        end else begin
          finish = 1'b1;
        end
      end
      S_FIN: begin
        mem_we = 1'b1;
        finish = 1'b1;
      end
      S_RES: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (finish) begin
      if (out_free) begin
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        state_nxt = S_RES;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    qa <= mem[ra_a];
    qb <= mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    v_r       <= v_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    if (load_out) begin
      out_rsp_r.popped_value <= res_val_nxt;
      out_rsp_r.status       <= res_st_nxt;
      out_rsp_r.entry_count  <= bmhq_pkg::COUNT_W'(count_nxt);
    end
  end

endmodule

// ===== rtl/bmhq_checker.sv =====
// Port-level checker for the binary min-heap queue and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmhq_checker #(
  parameter int CAPACITY = 1024
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input bmhq_pkg::in_item_t  in_req,
  input logic                out_valid,
  input logic                out_ready,
  input bmhq_pkg::out_item_t out_rsp
);

  localparam logic [bmhq_pkg::COUNT_W-1:0] CNT_FULL = bmhq_pkg::COUNT_W'(CAPACITY);

  `BMHQ_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_rsp), "Result changed or dropped while stalled.")
  `BMHQ_ASSERT_RST(a_empty_rsp, clk, rst_n, out_valid && out_rsp.status == bmhq_pkg::ST_EMPTY |-> out_rsp.entry_count == '0 && out_rsp.popped_value == '0, "Empty status with a nonzero count or value.")
  `BMHQ_ASSERT_RST(a_full_rsp, clk, rst_n, out_valid && out_rsp.status == bmhq_pkg::ST_FULL |-> out_rsp.entry_count == CNT_FULL && out_rsp.popped_value == '0, "Full status while the queue is not full.")
  `BMHQ_ASSERT_RST(a_req_known, clk, rst_n, in_valid && in_ready |-> !$isunknown(in_req), "Unknown request.")
  `BMHQ_ASSERT_CLK(a_reset_quiet, clk, !rst_n |=> !out_valid, "Result shown right after reset.")

endmodule

bind binary_min_heap_queue bmhq_checker #(
  .CAPACITY(CAPACITY)
) u_bmhq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);
